>>> src/mrhc_pkg.sv
package mrhc_pkg;

  localparam int NUM_ROOMS  = 8;
  localparam int HIST_DEPTH = 8;

  localparam int ROOM_W  = 3;
  localparam int VAL_W   = 12;
  localparam int SP_W    = 11;
  localparam int RES_W   = 11;
  localparam int KIND_W  = 2;
  localparam int BAND_W  = 8;
  localparam int LIM_W   = 11;
  localparam int CNT_W   = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
  localparam int MAIN_W  = $clog2(NUM_ROOMS + 1);
  localparam int SLOT_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int ADDR_W  = CNT_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_ROOMS << SLOT_W;
  localparam int ERR_W   = 14;
  localparam int PROD_W  = 23;
  localparam int D7_W    = 17;
  localparam int SUM_W   = 19;
  localparam int VSUM_W  = 16;

  localparam int TEMP_RESET = 400;
  localparam int VALVE_FULL = 1600;
  localparam int GAIN_NUM   = 205;
  localparam int GAIN_SHIFT = 11;

  localparam logic [KIND_W-1:0] KIND_VALVE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOILER  = 2'd2;

  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_BAND      = 3'd0;
  localparam logic [2:0] REG_LOW       = 3'd1;
  localparam logic [2:0] REG_HIGH_STD  = 3'd2;
  localparam logic [2:0] REG_HIGH_FLR  = 3'd3;
  localparam logic [2:0] REG_FLOOR_IDX = 3'd4;

  typedef struct packed {
    logic             accept;
    logic             rd_old;
    logic             latch_new;
    logic             calc;
    logic             select;
    logic             emit_valve;
    logic             emit_none;
    logic             boil_mul;
    logic             boil_upd;
    logic             emit_boiler;
    logic [CNT_W-1:0] room;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic sel_run;
  } status_t;

endpackage

>>> src/mrhc_ctrl.sv
module mrhc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic                in_end_of_tick,
  input  mrhc_pkg::status_t   status,
  output mrhc_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD_NEW = 4'd1;
  localparam logic [3:0] S_RD_OLD = 4'd2;
  localparam logic [3:0] S_CALC   = 4'd3;
  localparam logic [3:0] S_SEL    = 4'd4;
  localparam logic [3:0] S_EMIT   = 4'd5;
  localparam logic [3:0] S_NONE   = 4'd6;
  localparam logic [3:0] S_BMUL   = 4'd7;
  localparam logic [3:0] S_BUPD   = 4'd8;
  localparam logic [3:0] S_BOUT   = 4'd9;

  localparam logic [mrhc_pkg::CNT_W-1:0] LAST_ROOM =
    mrhc_pkg::CNT_W'(mrhc_pkg::NUM_ROOMS - 1);

  logic [3:0]                 state_r, state_nxt;
  logic [mrhc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.room  = cnt_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && !in_func && in_end_of_tick) begin
          state_nxt = S_RD_NEW;
          cnt_nxt   = '0;
        end
      end
      S_RD_NEW: begin
        state_nxt = S_RD_OLD;
      end
      S_RD_OLD: begin
        cmd.rd_old    = 1'b1;
        cmd.latch_new = 1'b1;
        state_nxt     = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (cnt_r == LAST_ROOM) begin
          state_nxt = S_SEL;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_RD_NEW;
        end
      end
      S_SEL: begin
        cmd.select = 1'b1;
        state_nxt  = status.sel_run ? S_EMIT : S_NONE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_valve = 1'b1;
          if (cnt_r == LAST_ROOM) begin
            state_nxt = S_BMUL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_NONE: begin
        if (status.out_free) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_BUPD;
        end
      end
      S_BMUL: begin
        cmd.boil_mul = 1'b1;
        state_nxt    = S_BUPD;
      end
      S_BUPD: begin
        cmd.boil_upd = 1'b1;
        state_nxt    = S_BOUT;
      end
      S_BOUT: begin
        if (status.out_free) begin
          cmd.emit_boiler = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> src/mrhc_datapath.sv
module mrhc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mrhc_pkg::cmd_t                      cmd,
  output mrhc_pkg::status_t                   status,
  input  logic                                in_func,
  input  logic [mrhc_pkg::ROOM_W-1:0]         in_room,
  input  logic signed [mrhc_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_opened,
  input  logic                                in_end_of_tick,
  input  logic [mrhc_pkg::BAND_W-1:0]         reg_band,
  input  logic [mrhc_pkg::LIM_W-1:0]          boiler_low_limit,
  input  logic [mrhc_pkg::LIM_W-1:0]          boiler_high_standard,
  input  logic [mrhc_pkg::LIM_W-1:0]          boiler_high_floor,
  input  logic [mrhc_pkg::ROOM_W-1:0]         floor_room_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mrhc_pkg::KIND_W-1:0]         out_kind,
  output logic [mrhc_pkg::ROOM_W-1:0]         out_room_res,
  output logic [mrhc_pkg::RES_W-1:0]          out_value_res,
  output logic                                out_last
);

  localparam int N = mrhc_pkg::NUM_ROOMS;
  localparam int CW = mrhc_pkg::CNT_W;
  localparam int SW = mrhc_pkg::SLOT_W;
  localparam int EW = mrhc_pkg::ERR_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(mrhc_pkg::HIST_DEPTH - 1);
  localparam logic [mrhc_pkg::MAIN_W-1:0] NO_MAIN = mrhc_pkg::MAIN_W'(N);
  localparam logic [mrhc_pkg::RES_W-1:0] FULL = mrhc_pkg::RES_W'(mrhc_pkg::VALVE_FULL);

  logic signed [mrhc_pkg::VAL_W-1:0] mem [mrhc_pkg::MEM_DEPTH];
  logic [mrhc_pkg::MEM_DEPTH-1:0]    mem_vld_r;
  logic signed [mrhc_pkg::VAL_W-1:0] rdata_r;
  logic                              rvld_r;
  logic signed [mrhc_pkg::VAL_W-1:0] hist_val;
  logic signed [mrhc_pkg::VAL_W-1:0] newest_r;

  logic [SW-1:0]                ptr_r;
  logic [SW-1:0]                ptr_inc;
  logic [SW-1:0]                old_slot;
  logic [mrhc_pkg::ADDR_W-1:0]  waddr;
  logic [mrhc_pkg::ADDR_W-1:0]  raddr;
  logic                         room_ok;
  logic                         we;

  logic [mrhc_pkg::SP_W-1:0]    sp_r [N];
  logic [N-1:0]                 open_r;
  logic [mrhc_pkg::RES_W-1:0]   valve_r [N];
  logic signed [EW-1:0]         e_r [N];
  logic signed [EW-1:0]         d_r [N];
  logic [N-1:0]                 under_r;
  logic [N-1:0]                 over_r;
  logic [mrhc_pkg::MAIN_W-1:0]  main_r, main_nxt;
  logic                         run_r, run_nxt;
  logic [mrhc_pkg::RES_W-1:0]   boiler_r;
  logic                         flim_r;

  logic [CW-1:0]                sp_idx;
  logic [mrhc_pkg::SP_W-1:0]    sp_sel;
  logic signed [EW-1:0]         e_calc, d_calc, band_s;
  logic [CW-1:0]                ed_idx;
  logic signed [EW-1:0]         e_sel, d_sel;

  logic [N-1:0]                 cand;
  logic [mrhc_pkg::MAIN_W-1:0]  poss, req;
  logic                         main_ok;

  logic signed [mrhc_pkg::VSUM_W-1:0] vsum;
  logic [mrhc_pkg::RES_W-1:0]   valve_new;

  logic signed [mrhc_pkg::PROD_W-1:0] prod_r;
  logic signed [mrhc_pkg::D7_W-1:0]   d7_r;
  logic signed [mrhc_pkg::D7_W-1:0]   d_x;
  logic                         bu_r, bo_r;
  logic [mrhc_pkg::LIM_W-1:0]   hi;
  logic signed [mrhc_pkg::SUM_W-1:0] t, hi_s, lo_s, hf_s;
  logic                         floor_on;

  logic                         out_valid_r;
  logic [mrhc_pkg::KIND_W-1:0]  kind_r;
  logic [mrhc_pkg::ROOM_W-1:0]  room_res_r;
  logic [mrhc_pkg::RES_W-1:0]   value_res_r;
  logic                         last_r;
  logic                         load;

  assign room_ok  = ({1'b0, in_room} < (mrhc_pkg::ROOM_W + 1)'(N));
  assign ptr_inc  = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
  assign old_slot = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
  assign we       = cmd.accept && !in_func && room_ok;
  assign waddr    = {CW'(in_room), ptr_inc};
  assign raddr    = {cmd.room, cmd.rd_old ? old_slot : ptr_r};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_value;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      if (we) begin
        mem_vld_r[waddr] <= 1'b1;
      end
      rvld_r <= mem_vld_r[raddr];
    end
  end

  assign hist_val = rvld_r ? rdata_r : mrhc_pkg::VAL_W'(mrhc_pkg::TEMP_RESET);

  assign sp_idx = cmd.calc ? cmd.room : CW'(floor_room_index);
  assign sp_sel = sp_r[sp_idx];
  assign e_calc = $signed({{(EW - mrhc_pkg::SP_W){1'b0}}, sp_sel}) - EW'(newest_r);
  assign d_calc = EW'(newest_r) - EW'(hist_val);
  assign band_s = $signed({{(EW - mrhc_pkg::BAND_W){1'b0}}, reg_band});

  assign ed_idx = cmd.boil_mul ? main_r[CW-1:0] : cmd.room;
  assign e_sel  = e_r[ed_idx];
  assign d_sel  = d_r[ed_idx];

  always_comb begin
    poss = NO_MAIN;
    req  = NO_MAIN;
    for (int r = 0; r < N; r++) begin
      cand[r] = (sp_r[r] != '0) && open_r[r] && (main_r != mrhc_pkg::MAIN_W'(r));
      if (cand[r]) begin
        poss = mrhc_pkg::MAIN_W'(r);
        if (under_r[r]) begin
          req = mrhc_pkg::MAIN_W'(r);
        end
      end
    end
    main_ok  = (main_r < NO_MAIN);
    main_nxt = main_r;
    run_nxt  = 1'b1;
    if (main_ok && under_r[main_r[CW-1:0]]) begin
      main_nxt = main_r;
    end else if (req != NO_MAIN) begin
      main_nxt = req;
    end else if (!main_ok || over_r[main_r[CW-1:0]]) begin
      if (poss != NO_MAIN) begin
        main_nxt = poss;
      end else begin
        run_nxt = 1'b0;
      end
    end
  end

  assign status.sel_run  = run_nxt;
  assign load            = !out_valid_r || out_ready;
  assign status.out_free = load;

  always_comb begin
    vsum = $signed({{(mrhc_pkg::VSUM_W - mrhc_pkg::RES_W){1'b0}}, valve_r[cmd.room]})
         + mrhc_pkg::VSUM_W'(e_sel) - mrhc_pkg::VSUM_W'(d_sel);
    if (main_r == mrhc_pkg::MAIN_W'(cmd.room)) begin
      valve_new = FULL;
    end else if (under_r[cmd.room]) begin
      valve_new = FULL;
    end else if (over_r[cmd.room]) begin
      valve_new = '0;
    end else if (vsum > mrhc_pkg::VSUM_W'(mrhc_pkg::VALVE_FULL)) begin
      valve_new = FULL;
    end else if (vsum < 0) begin
      valve_new = '0;
    end else begin
      valve_new = vsum[mrhc_pkg::RES_W-1:0];
    end
  end

  assign d_x = mrhc_pkg::D7_W'(d_sel);

  always_comb begin
    hi   = flim_r ? boiler_high_floor : boiler_high_standard;
    hi_s = $signed({{(mrhc_pkg::SUM_W - mrhc_pkg::LIM_W){1'b0}}, hi});
    lo_s = $signed({{(mrhc_pkg::SUM_W - mrhc_pkg::LIM_W){1'b0}}, boiler_low_limit});
    hf_s = $signed({{(mrhc_pkg::SUM_W - mrhc_pkg::LIM_W){1'b0}}, boiler_high_floor});
    floor_on = ({1'b0, floor_room_index} < (mrhc_pkg::ROOM_W + 1)'(N)) && (sp_sel != '0);
    if (!run_r) begin
      t = '0;
    end else begin
      if (bu_r) begin
        t = hi_s;
      end else if (bo_r) begin
        t = lo_s;
      end else begin
        t = $signed({{(mrhc_pkg::SUM_W - mrhc_pkg::RES_W){1'b0}}, boiler_r})
          + mrhc_pkg::SUM_W'(prod_r >>> mrhc_pkg::GAIN_SHIFT)
          - mrhc_pkg::SUM_W'(d7_r);
      end
      if (t > hi_s) begin
        t = hi_s;
      end else if (t < lo_s) begin
        t = lo_s;
      end
    end
    if (floor_on && (t > hf_s)) begin
      t = hf_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_new) begin
      newest_r <= hist_val;
    end
    if (cmd.calc) begin
      e_r[cmd.room] <= e_calc;
      d_r[cmd.room] <= d_calc;
      under_r[cmd.room] <= (e_calc > band_s);
      over_r[cmd.room]  <= (e_calc < -band_s);
    end
    if (cmd.boil_mul) begin
      prod_r <= mrhc_pkg::PROD_W'(e_sel) * $signed(mrhc_pkg::PROD_W'(mrhc_pkg::GAIN_NUM));
      d7_r   <= (d_x <<< 3) - d_x;
      bu_r   <= under_r[ed_idx];
      bo_r   <= over_r[ed_idx];
    end
    if (load && (cmd.emit_valve || cmd.emit_none || cmd.emit_boiler)) begin
      last_r <= cmd.emit_boiler;
      if (cmd.emit_valve) begin
        kind_r      <= mrhc_pkg::KIND_VALVE;
        room_res_r  <= mrhc_pkg::ROOM_W'(cmd.room);
        value_res_r <= valve_new;
      end else if (cmd.emit_none) begin
        kind_r      <= mrhc_pkg::KIND_DEFAULT;
        room_res_r  <= '0;
        value_res_r <= '0;
      end else begin
        kind_r      <= mrhc_pkg::KIND_BOILER;
        room_res_r  <= '0;
        value_res_r <= boiler_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      open_r      <= '0;
      main_r      <= NO_MAIN;
      run_r       <= 1'b0;
      boiler_r    <= '0;
      flim_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < N; r++) begin
        sp_r[r]    <= '0;
        valve_r[r] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        if (in_func) begin
          if (room_ok) begin
            sp_r[CW'(in_room)] <= in_value[mrhc_pkg::VAL_W-1] ? '0
                                : in_value[mrhc_pkg::SP_W-1:0];
          end
        end else begin
          if (room_ok) begin
            open_r[CW'(in_room)] <= in_opened;
          end
          if (in_end_of_tick) begin
            ptr_r <= ptr_inc;
          end
        end
      end
      if (cmd.select) begin
        main_r <= main_nxt;
        run_r  <= run_nxt;
      end
      if (cmd.emit_valve && load) begin
        valve_r[cmd.room] <= valve_new;
      end
      if (cmd.boil_upd) begin
        boiler_r <= t[mrhc_pkg::RES_W-1:0];
        flim_r   <= floor_on;
      end
      if (load && (cmd.emit_valve || cmd.emit_none || cmd.emit_boiler)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_room_res  = room_res_r;
  assign out_value_res = value_res_r;
  assign out_last      = last_r;

endmodule

>>> src/multi_room_heating_controller_core.sv
// Multi-room heating controller.
// Input channel (in_*): room samples (func 0) and setpoint writes (func 1).
// A sample with end_of_tick set closes the tick and starts the control pass.
// Result channel (out_*): a normal pass gives one valve opening per room in
// room order, then the boiler setpoint with last set. When no main room can
// be chosen it gives one all-valves-default item and a zero boiler setpoint.
// Setpoint writes and samples without end_of_tick give no result. A closing
// sample fetches the newest and oldest history entries of each room in turn
// through the single read port of the history memory, then selects the main
// room, sends the valve items one at a time as the result register frees,
// updates the boiler and then sends the boiler item.
// The input is held off during the control pass.
// The result register holds an item while out_ready is low and the pass
// waits; the next input is taken while the last result still waits.
// After reset the history reads as 25 C, setpoints and valves are zero,
// no main room is chosen and the registers hold their reset values.
// Registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16.
module multi_room_heating_controller_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [mrhc_pkg::ROOM_W-1:0]       in_room,
  input  logic signed [mrhc_pkg::VAL_W-1:0] in_value,
  input  logic                              in_opened,
  input  logic                              in_end_of_tick,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mrhc_pkg::KIND_W-1:0]       out_kind,
  output logic [mrhc_pkg::ROOM_W-1:0]       out_room_res,
  output logic [mrhc_pkg::RES_W-1:0]        out_value_res,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mrhc_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [mrhc_pkg::BAND_W-1:0] band_r;
  logic [mrhc_pkg::LIM_W-1:0]  low_r;
  logic [mrhc_pkg::LIM_W-1:0]  high_std_r;
  logic [mrhc_pkg::LIM_W-1:0]  high_flr_r;
  logic [mrhc_pkg::ROOM_W-1:0] floor_idx_r;
  logic [2:0]                  reg_idx;
  logic                        wr_en;
  mrhc_pkg::cmd_t              cmd;
  mrhc_pkg::status_t           status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r      <= 8'd8;
      low_r       <= 11'd480;
      high_std_r  <= 11'd1120;
      high_flr_r  <= 11'd720;
      floor_idx_r <= '0;
    end else if (wr_en && (paddr[1:0] == 2'b00)) begin
      case (reg_idx)
        mrhc_pkg::REG_BAND:      band_r      <= pwdata[mrhc_pkg::BAND_W-1:0];
        mrhc_pkg::REG_LOW:       low_r       <= pwdata[mrhc_pkg::LIM_W-1:0];
        mrhc_pkg::REG_HIGH_STD:  high_std_r  <= pwdata[mrhc_pkg::LIM_W-1:0];
        mrhc_pkg::REG_HIGH_FLR:  high_flr_r  <= pwdata[mrhc_pkg::LIM_W-1:0];
        mrhc_pkg::REG_FLOOR_IDX: floor_idx_r <= pwdata[mrhc_pkg::ROOM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mrhc_pkg::REG_BAND:      prdata = 32'(band_r);
      mrhc_pkg::REG_LOW:       prdata = 32'(low_r);
      mrhc_pkg::REG_HIGH_STD:  prdata = 32'(high_std_r);
      mrhc_pkg::REG_HIGH_FLR:  prdata = 32'(high_flr_r);
      mrhc_pkg::REG_FLOOR_IDX: prdata = 32'(floor_idx_r);
      default:                 prdata = '0;
    endcase
  end

  mrhc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_end_of_tick (in_end_of_tick),
    .status         (status),
    .cmd            (cmd)
  );

  mrhc_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_func              (in_func),
    .in_room              (in_room),
    .in_value             (in_value),
    .in_opened            (in_opened),
    .in_end_of_tick       (in_end_of_tick),
    .reg_band             (band_r),
    .boiler_low_limit     (low_r),
    .boiler_high_standard (high_std_r),
    .boiler_high_floor    (high_flr_r),
    .floor_room_index     (floor_idx_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_room_res         (out_room_res),
    .out_value_res        (out_value_res),
    .out_last             (out_last)
  );

endmodule

>>> src/mrhc_checker.sv
module mrhc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mrhc_pkg::KIND_W-1:0] out_kind,
  input logic [mrhc_pkg::ROOM_W-1:0] out_room_res,
  input logic [mrhc_pkg::RES_W-1:0]  out_value_res,
  input logic                        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res) && $stable(out_kind))
    else $error("result item changed while stalled");

  a_last_boiler: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == mrhc_pkg::KIND_BOILER)))
    else $error("last flag does not mark the boiler item");

  a_valve_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == mrhc_pkg::KIND_VALVE)
      |-> (out_value_res <= mrhc_pkg::RES_W'(mrhc_pkg::VALVE_FULL)))
    else $error("valve opening above full scale");

  a_default_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == mrhc_pkg::KIND_DEFAULT)
      |-> (out_room_res == '0) && (out_value_res == '0))
    else $error("default item carries data");

  a_no_input_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && in_valid |-> !in_ready)
    else $error("input taken during a control pass");

endmodule

bind multi_room_heating_controller_core mrhc_checker u_mrhc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_room_res  (out_room_res),
  .out_value_res (out_value_res),
  .out_last      (out_last)
);

>>> sim/multi_room_heating_controller_core_tb.sv
`timescale 1ns / 100ps

module multi_room_heating_controller_core_tb;

  typedef struct packed {
    logic                                func;
    logic [mrhc_pkg::ROOM_W-1:0]         room;
    logic signed [mrhc_pkg::VAL_W-1:0]   value;
    logic                                opened;
    logic                                eot;
  } sample_t;

  typedef struct packed {
    logic [mrhc_pkg::KIND_W-1:0] kind;
    logic [mrhc_pkg::ROOM_W-1:0] room;
    logic [mrhc_pkg::RES_W-1:0]  value;
    logic                        last;
  } result_t;

  localparam int FUNC_SAMPLE = 0;
  localparam int FUNC_SETPOINT = 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [mrhc_pkg::ROOM_W-1:0] in_room = '0;
  logic signed [mrhc_pkg::VAL_W-1:0] in_value = '0;
  logic in_opened = 1'b0;
  logic in_end_of_tick = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [mrhc_pkg::KIND_W-1:0] out_kind;
  logic [mrhc_pkg::ROOM_W-1:0] out_room_res;
  logic [mrhc_pkg::RES_W-1:0] out_value_res;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mrhc_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multi_room_heating_controller_core u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state.
  int band, low_lim, high_std, high_flr, floor_idx;
  int hist [mrhc_pkg::NUM_ROOMS][mrhc_pkg::HIST_DEPTH];
  int hptr;
  int setp [mrhc_pkg::NUM_ROOMS];
  bit open_flag [mrhc_pkg::NUM_ROOMS];
  int valve [mrhc_pkg::NUM_ROOMS];
  int main_rm;
  int boiler;
  bit floor_on;

  result_t expected_q[$];
  sample_t item_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int errors = 0;
  longint cycles = 0;
  logic in_ready_q = 1'b0;

  function automatic int room_err(int r);
    return setp[r] - hist[r][hptr];
  endfunction

  function automatic int room_deriv(int r);
    return hist[r][hptr] - hist[r][(hptr + 1) % mrhc_pkg::HIST_DEPTH];
  endfunction

  function automatic int fdiv2048(int x);
    if (x >= 0) return x >>> 11;
    return -((-x + 2047) >>> 11);
  endfunction

  function automatic void push_result(int k, int r, int v, bit l);
    result_t x;
    x.kind = k[mrhc_pkg::KIND_W-1:0];
    x.room = r[mrhc_pkg::ROOM_W-1:0];
    x.value = (v < 0) ? '0 : v[mrhc_pkg::RES_W-1:0];
    x.last = l;
    expected_q.push_back(x);
  endfunction

  function automatic void predict_control(sample_t s);
    int r, e, v, hi, lo, t, poss, req;
    bit run;
    int sval;
    poss = mrhc_pkg::NUM_ROOMS;
    req = mrhc_pkg::NUM_ROOMS;
    run = 1;
    sval = $signed(s.value);
    if (s.func == FUNC_SETPOINT) begin
      setp[s.room] = (sval < 0) ? 0 : sval;
      return;
    end
    hist[s.room][(hptr + 1) % mrhc_pkg::HIST_DEPTH] = sval;
    open_flag[s.room] = s.opened;
    if (!s.eot) return;
    hptr = (hptr + 1) % mrhc_pkg::HIST_DEPTH;
    for (r = 0; r < mrhc_pkg::NUM_ROOMS; r++) begin
      if (r != main_rm && setp[r] > 0 && open_flag[r]) begin
        poss = r;
        if (room_err(r) > band) req = r;
      end
    end
    if (main_rm < mrhc_pkg::NUM_ROOMS && room_err(main_rm) > band) begin
    end else if (req < mrhc_pkg::NUM_ROOMS) begin
      main_rm = req;
    end else if (main_rm >= mrhc_pkg::NUM_ROOMS || room_err(main_rm) < -band) begin
      if (poss < mrhc_pkg::NUM_ROOMS) main_rm = poss;
      else run = 0;
    end
    if (run) begin
      for (r = 0; r < mrhc_pkg::NUM_ROOMS; r++) begin
        if (r == main_rm) continue;
        e = room_err(r);
        v = valve[r];
        if (e > band) v = mrhc_pkg::VALVE_FULL;
        else if (e < -band) v = 0;
        else v = v + e - room_deriv(r);
        if (v > mrhc_pkg::VALVE_FULL) v = mrhc_pkg::VALVE_FULL;
        else if (v < 0) v = 0;
        valve[r] = v;
      end
      hi = floor_on ? high_flr : high_std;
      lo = low_lim;
      e = room_err(main_rm);
      t = boiler;
      valve[main_rm] = mrhc_pkg::VALVE_FULL;
      if (e > band) t = hi;
      else if (e < -band) t = lo;
      else t = t + fdiv2048(e * mrhc_pkg::GAIN_NUM) - 7 * room_deriv(main_rm);
      if (t > hi) t = hi;
      else if (t < lo) t = lo;
      boiler = t;
    end else begin
      boiler = 0;
    end
    if (floor_idx < mrhc_pkg::NUM_ROOMS && setp[floor_idx] > 0) begin
      floor_on = 1;
      if (boiler > high_flr) boiler = high_flr;
    end else begin
      floor_on = 0;
    end
    if (run) begin
      for (r = 0; r < mrhc_pkg::NUM_ROOMS; r++)
        push_result(mrhc_pkg::KIND_VALVE, r, valve[r], 0);
    end else begin
      push_result(mrhc_pkg::KIND_DEFAULT, 0, 0, 0);
    end
    push_result(mrhc_pkg::KIND_BOILER, 0, boiler, 1);
  endfunction

  // Driver.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_ready_q)) begin
      if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_t s;
        s = item_q.pop_front();
        in_valid <= 1'b1;
        in_func <= s.func;
        in_room <= s.room;
        in_value <= s.value;
        in_opened <= s.opened;
        in_end_of_tick <= s.eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_ready_q <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      sample_t s;
      s = {in_func, in_room, in_value, in_opened, in_end_of_tick};
      predict_control(s);
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result item kind=%0d value=%0d", out_kind, out_value_res);
        errors++;
      end else begin
        result_t x;
        x = expected_q.pop_front();
        if (out_kind !== x.kind) begin
          $error("kind expected %0d actual %0d", x.kind, out_kind); errors++;
        end
        if (out_room_res !== x.room) begin
          $error("room_res expected %0d actual %0d", x.room, out_room_res); errors++;
        end
        if (out_value_res !== x.value) begin
          $error("value_res expected %0d actual %0d", x.value, out_value_res); errors++;
        end
        if (out_last !== x.last) begin
          $error("last expected %0d actual %0d", x.last, out_last); errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic cfg_write(int idx, int val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= mrhc_pkg::PADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      mrhc_pkg::REG_BAND:      band = val & 8'hFF;
      mrhc_pkg::REG_LOW:       low_lim = val & 11'h7FF;
      mrhc_pkg::REG_HIGH_STD:  high_std = val & 11'h7FF;
      mrhc_pkg::REG_HIGH_FLR:  high_flr = val & 11'h7FF;
      mrhc_pkg::REG_FLOOR_IDX: floor_idx = val & 7;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (item_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic sample_t mk(int f, int r, int v, int o, int e);
    sample_t s;
    s.func = f; s.room = r; s.value = v; s.opened = o; s.eot = e;
    return s;
  endfunction

  function automatic int rand_temp();
    case ($urandom_range(9))
      0: return -640;
      1: return 2000;
      2: return $urandom_range(2640) - 640;
      3: return $urandom_range(4095) - 2048;
      default: return 280 + $urandom_range(160);
    endcase
  endfunction

  task automatic add_tick(bit full);
    int r;
    for (r = 0; r < mrhc_pkg::NUM_ROOMS; r++) begin
      if ($urandom_range(7) == 0)
        item_q.push_back(mk(FUNC_SETPOINT, $urandom_range(7),
                            $urandom_range(3) == 0 ? rand_temp() : 320 + $urandom_range(80),
                            $urandom_range(1), $urandom_range(1)));
      if (full || $urandom_range(3) != 0)
        item_q.push_back(mk(FUNC_SAMPLE, r, rand_temp(), $urandom_range(4) != 0,
                            (r == mrhc_pkg::NUM_ROOMS - 1) || (!full && $urandom_range(9) == 0)));
    end
    if (!full) item_q.push_back(mk(FUNC_SAMPLE, $urandom_range(7), rand_temp(),
                                   $urandom_range(1), 1));
  endtask

  initial begin
    int ph, n, r;
    band = 8; low_lim = 480; high_std = 1120; high_flr = 720; floor_idx = 0;
    for (r = 0; r < mrhc_pkg::NUM_ROOMS; r++) begin
      for (n = 0; n < mrhc_pkg::HIST_DEPTH; n++) hist[r][n] = mrhc_pkg::TEMP_RESET;
      setp[r] = 0; open_flag[r] = 0; valve[r] = 0;
    end
    hptr = 0; main_rm = mrhc_pkg::NUM_ROOMS; boiler = 0; floor_on = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: no main room, setpoints incl. negative, extremes, out-of-band.
    item_q.push_back(mk(FUNC_SAMPLE, 0, 400, 1, 1));
    item_q.push_back(mk(FUNC_SETPOINT, 2, -1, 1, 1));
    item_q.push_back(mk(FUNC_SETPOINT, 1, 2000, 0, 0));
    item_q.push_back(mk(FUNC_SETPOINT, 3, 360, 0, 0));
    item_q.push_back(mk(FUNC_SETPOINT, 0, 400, 0, 0));
    item_q.push_back(mk(FUNC_SAMPLE, 1, -640, 1, 0));
    item_q.push_back(mk(FUNC_SAMPLE, 3, 2000, 1, 0));
    item_q.push_back(mk(FUNC_SAMPLE, 0, 398, 1, 0));
    item_q.push_back(mk(FUNC_SAMPLE, 0, 403, 0, 0));
    item_q.push_back(mk(FUNC_SAMPLE, 2, -2048, 1, 1));
    item_q.push_back(mk(FUNC_SAMPLE, 1, 2047, 1, 0));
    item_q.push_back(mk(FUNC_SAMPLE, 3, 355, 1, 1));
    item_q.push_back(mk(FUNC_SETPOINT, 1, 0, 0, 0));
    item_q.push_back(mk(FUNC_SAMPLE, 3, 340, 1, 1));
    item_q.push_back(mk(FUNC_SAMPLE, 7, -1, 0, 1));
    wait_drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(mrhc_pkg::REG_BAND, 0); cfg_write(mrhc_pkg::REG_LOW, 0);
          cfg_write(mrhc_pkg::REG_HIGH_STD, 1600); cfg_write(mrhc_pkg::REG_HIGH_FLR, 1600);
          cfg_write(mrhc_pkg::REG_FLOOR_IDX, 7);
        end
        1: begin
          cfg_write(mrhc_pkg::REG_BAND, 160); cfg_write(mrhc_pkg::REG_LOW, 1600);
          cfg_write(mrhc_pkg::REG_HIGH_STD, 0); cfg_write(mrhc_pkg::REG_HIGH_FLR, 0);
          cfg_write(mrhc_pkg::REG_FLOOR_IDX, 0);
        end
        default: begin
          cfg_write(mrhc_pkg::REG_BAND, $urandom_range(160));
          cfg_write(mrhc_pkg::REG_LOW, $urandom_range(800));
          cfg_write(mrhc_pkg::REG_HIGH_STD, $urandom_range(1600));
          cfg_write(mrhc_pkg::REG_HIGH_FLR, $urandom_range(1600));
          cfg_write(mrhc_pkg::REG_FLOOR_IDX, $urandom_range(7));
        end
      endcase
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 33 : 69) : 0;
      recv_stall_pct = (ph % 4 == 2) ? 69 : (ph % 4 == 3 ? 33 : 0);
      if (ph == 2) hold_off = 300;
      for (n = 0; n < 5; n++) add_tick($urandom_range(3) != 0);
      wait_drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
